// File: design/ctf_pkg.sv
// ctf_pkg: widths, register indexes, command/status structs and the cordic
// arctangent table shared by the complementary tilt filter modules
// no dependencies
package ctf_pkg;

	// register indexes on the configuration channel
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ELAPSED  = 2'd1;

	localparam logic [16:0] BLEND_RESET   = 17'd64225;
	localparam logic [31:0] ELAPSED_RESET = 32'd500000;

	// cordic table and datapath widths
	localparam int ANG_TABLE_LEN = 24;
	localparam int STEP_W        = 5;
	localparam int XY_W          = 28;
	localparam int ANG_W         = 26;
	localparam int ACC_W         = 18;
	localparam int TAB_W         = 22;

	// 180 degrees in degrees times 65536
	localparam logic signed [ANG_W-1:0] HALF_TURN = 26'sd11796480;

	// round(180/pi/4e6 * 2^40)
	localparam logic [23:0] GYRO_K = 24'd15749344;

	localparam logic signed [23:0] ANGLE_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] ANGLE_MIN = 24'sh800000;

	typedef struct packed {
		logic              load;
		logic              iter;
		logic              mul1;
		logic              mul2;
		logic              gsum;
		logic              inner;
		logic              blend;
		logic              fin;
		logic              out_load;
		logic [STEP_W-1:0] step;
	} ctf_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctf_sts_t;

	// atan(2^-i) in degrees times 65536
	function automatic logic [TAB_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
		logic [TAB_W-1:0] v;
		case (idx)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			5'd21:   v = 22'd2;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// File: design/ctf_if.sv
// ctf_if: sample, result and configuration channel interfaces
// depends on ctf_pkg
interface ctf_in_if;
	import ctf_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_rate;
	logic [31:0]        timestamp_us;
	modport source (output valid, accel_y, accel_z, gyro_rate, timestamp_us, input ready);
	modport sink (input valid, accel_y, accel_z, gyro_rate, timestamp_us, output ready);
endinterface

interface ctf_out_if;
	import ctf_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [23:0] tilt_angle;
	logic               updated;
	modport source (output valid, tilt_angle, updated, input ready);
	modport sink (input valid, tilt_angle, updated, output ready);
endinterface

interface ctf_cfg_if;
	import ctf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/ctf_ctrl.sv
// ctf_ctrl: sequencer for the tilt filter, walks one sample through the
// cordic steps and the gyro/blend stages; depends on ctf_pkg
module ctf_ctrl #(
	parameter int NSTEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ctf_pkg::ctf_sts_t sts,
	output ctf_pkg::ctf_cmd_t cmd
);
	import ctf_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ITER  = 4'd1;
	localparam logic [3:0] S_MUL1  = 4'd2;
	localparam logic [3:0] S_MUL2  = 4'd3;
	localparam logic [3:0] S_GSUM  = 4'd4;
	localparam logic [3:0] S_INNER = 4'd5;
	localparam logic [3:0] S_BLEND = 4'd6;
	localparam logic [3:0] S_FIN   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

	logic [3:0]        state_q;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		cmd      = '0;
		cmd.step = step_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE:  cmd.load     = in_valid;
			S_ITER:  cmd.iter     = 1'b1;
			S_MUL1:  cmd.mul1     = 1'b1;
			S_MUL2:  cmd.mul2     = 1'b1;
			S_GSUM:  cmd.gsum     = 1'b1;
			S_INNER: cmd.inner    = 1'b1;
			S_BLEND: cmd.blend    = 1'b1;
			S_FIN:   cmd.fin      = 1'b1;
			S_OUT:   cmd.out_load = sts.out_free;
			default: cmd          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (in_valid) state_q <= S_ITER;
				end
				S_ITER: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) state_q <= S_MUL1;
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_GSUM;
				S_GSUM:  state_q <= S_INNER;
				S_INNER: state_q <= S_BLEND;
				S_BLEND: state_q <= S_FIN;
				S_FIN:   state_q <= S_OUT;
				S_OUT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/ctf_datapath.sv
// ctf_datapath: cordic atan2 registers, gyro integration, blend, filter
// state, configuration registers and the result register; depends on ctf_pkg
module ctf_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctf_pkg::ctf_cmd_t             cmd,
	output ctf_pkg::ctf_sts_t             sts,
	input  logic signed [15:0]            accel_y,
	input  logic signed [15:0]            accel_z,
	input  logic signed [15:0]            gyro_rate,
	input  logic [31:0]                   timestamp_us,
	input  logic                          cfg_we,
	input  logic [ctf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic signed [23:0]            res_angle,
	output logic                          res_updated
);
	import ctf_pkg::*;

	// configuration
	logic [16:0] bw_q;
	logic [31:0] maxel_q;

	// filter state
	logic signed [23:0] angle_q;
	logic [31:0]        last_time_q;
	logic               seeded_q;

	// per-sample registers
	logic signed [XY_W-1:0]  x_q, y_q;
	logic signed [ANG_W-1:0] ang_q;
	logic                    zero_q;
	logic                    first_q;
	logic [31:0]             dt_q;
	logic [15:0]             gabs_q;
	logic                    gneg_q;
	logic                    rej_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [47:0]             mag_q;
	logic [51:0]             p1_q;
	logic [43:0]             p2_q;
	logic signed [33:0]      gterm_q;
	logic signed [34:0]      inner_q;
	logic signed [52:0]      m1_q;
	logic signed [35:0]      m2_q;
	logic                    upd_q;
	logic                    res_valid_q;

	// load values
	logic signed [XY_W-1:0]  x_ld, y_ld;
	logic signed [ANG_W-1:0] base_ld;

	assign x_ld    = {{(XY_W-24){accel_z[15]}}, accel_z, 8'h00};
	assign y_ld    = {{(XY_W-24){accel_y[15]}}, accel_y, 8'h00};
	assign base_ld = accel_y[15] ? -HALF_TURN : HALF_TURN;

	// one cordic step
	logic signed [XY_W-1:0]  dx, dy;
	logic signed [ANG_W-1:0] tab_s;

	assign dx    = y_q >>> cmd.step;
	assign dy    = x_q >>> cmd.step;
	assign tab_s = {{(ANG_W-TAB_W){1'b0}}, atan_entry(cmd.step)};

	// degrees times 256, rounded
	logic signed [ANG_W-1:0] ang_rnd;
	assign ang_rnd = ang_q + 26'sd128;

	// gyro products
	logic [47:0] mag_d;
	logic [51:0] p1_d;
	logic [43:0] p2_d;
	assign mag_d = {32'd0, gabs_q} * {16'd0, dt_q};
	assign p1_d  = {24'd0, mag_q[47:20]} * {28'd0, GYRO_K};
	assign p2_d  = {24'd0, mag_q[19:0]} * {20'd0, GYRO_K};

	logic [52:0] r_sum, r_rnd;
	assign r_sum = {1'b0, p1_q} + {29'd0, p2_q[43:20]};
	assign r_rnd = r_sum + 53'd524288;

	// blend weights
	logic [16:0] a_w, b_w;
	assign a_w = (bw_q > 17'h10000) ? 17'h10000 : bw_q;
	assign b_w = 17'h10000 - a_w;

	logic signed [52:0] m1_d;
	logic signed [35:0] m2_d;
	assign m1_d = $signed({1'b0, a_w}) * inner_q;
	assign m2_d = $signed({1'b0, b_w}) * acc_q;

	logic signed [53:0] mix;
	logic signed [37:0] shr;
	logic signed [23:0] blended;
	assign mix = {m1_q[52], m1_q} + {{18{m2_q[35]}}, m2_q} + 54'sd32768;
	assign shr = mix[53:16];

	always_comb begin
		if (shr > 38'(ANGLE_MAX))
			blended = ANGLE_MAX;
		else if (shr < 38'(ANGLE_MIN))
			blended = ANGLE_MIN;
		else
			blended = shr[23:0];
	end

	// control state: config, filter state, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q        <= BLEND_RESET;
			maxel_q     <= ELAPSED_RESET;
			angle_q     <= '0;
			last_time_q <= '0;
			seeded_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BLEND_WEIGHT: bw_q    <= cfg_data[16:0];
					REG_MAX_ELAPSED:  maxel_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				last_time_q <= timestamp_us;
				seeded_q    <= 1'b1;
			end
			if (cmd.fin) begin
				if (first_q)
					angle_q <= {{(24-ACC_W){acc_q[ACC_W-1]}}, acc_q};
				else if (!rej_q)
					angle_q <= blended;
			end
			if (cmd.out_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zero_q  <= (accel_y == 16'sd0) && (accel_z == 16'sd0);
			first_q <= !seeded_q;
			dt_q    <= timestamp_us - last_time_q;
			gabs_q  <= gyro_rate[15] ? 16'(-gyro_rate) : gyro_rate;
			gneg_q  <= gyro_rate[15];
			if (accel_z[15]) begin
				x_q   <= -x_ld;
				y_q   <= -y_ld;
				ang_q <= base_ld;
			end else begin
				x_q   <= x_ld;
				y_q   <= y_ld;
				ang_q <= '0;
			end
		end
		if (cmd.iter) begin
			if (!y_q[XY_W-1]) begin
				x_q   <= x_q + dx;
				y_q   <= y_q - dy;
				ang_q <= ang_q + tab_s;
			end else begin
				x_q   <= x_q - dx;
				y_q   <= y_q + dy;
				ang_q <= ang_q - tab_s;
			end
		end
		if (cmd.mul1) begin
			acc_q <= zero_q ? '0 : ang_rnd[ANG_W-1:8];
			mag_q <= mag_d;
			rej_q <= (dt_q == 32'd0) || (dt_q > maxel_q);
		end
		if (cmd.mul2) begin
			p1_q <= p1_d;
			p2_q <= p2_d;
		end
		if (cmd.gsum)
			gterm_q <= gneg_q ? -$signed({1'b0, r_rnd[52:20]}) : $signed({1'b0, r_rnd[52:20]});
		if (cmd.inner)
			inner_q <= {{11{angle_q[23]}}, angle_q} + {gterm_q[33], gterm_q};
		if (cmd.blend) begin
			m1_q <= m1_d;
			m2_q <= m2_d;
		end
		if (cmd.fin)
			upd_q <= first_q || !rej_q;
		if (cmd.out_load) begin
			res_angle   <= angle_q;
			res_updated <= upd_q;
		end
	end

	assign sts.out_free = !res_valid_q || res_ready;
	assign res_valid    = res_valid_q;

endmodule

// File: design/complementary_tilt_filter.sv
// complementary_tilt_filter: top level of the pitch complementary filter
// depends on ctf_pkg, ctf_if, ctf_ctrl and ctf_datapath
//
// usage
//  - sample channel: one beat per imu sample (accel y/z counts, gyro x rate
//    in rad/s times 1024, microsecond timestamp)
//  - result channel: exactly one beat per sample, pitch in degrees times 256
//    and an updated flag (low when the sample was rejected for a zero or
//    too long elapsed time)
//  - cfg channel: index 0 blend weight (q1.16, used up to 1.0), index 1 longest elapsed time
//    in us; always ready, write only while no sample is in flight
//  - sample beat to result valid: the iterative cordic does one micro-rotation
//    per cycle, followed by the gyro multiply and blend stages
//  - one sample in flight at a time: the next sample beat is taken only once
//    the previous result has been loaded into the output register
//  - reset clears the angle, the last timestamp and the seeded flag and
//    restores the register defaults; the first sample afterwards seeds
//  - a stalled receiver: the finished result sits in the output register
//    and the next sample is still taken; that sample then waits at the end
//    of its computation until the output register is free
module complementary_tilt_filter #(
	parameter int CORDIC_STEPS = 16
) (
	input logic      clk,
	input logic      arst_n,
	ctf_in_if.sink   sample,
	ctf_out_if.source result,
	ctf_cfg_if.sink  cfg
);
	import ctf_pkg::*;

	// table covers 24 micro-rotations at most
	localparam int NSTEPS = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_STEPS;

	ctf_cmd_t cmd;
	ctf_sts_t sts;

	// registers are always writable
	assign cfg.ready = 1'b1;

	// sequencer
	ctf_ctrl #(
		.NSTEPS(NSTEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// cordic, gyro integration, blend and result register
	ctf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.accel_y      (sample.accel_y),
		.accel_z      (sample.accel_z),
		.gyro_rate    (sample.gyro_rate),
		.timestamp_us (sample.timestamp_us),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.res_angle    (result.tilt_angle),
		.res_updated  (result.updated)
	);

endmodule

// File: design/ctf_checker.sv
// ctf_checker: port-level checks of the tilt filter, bound to the top level
// depends on the complementary_tilt_filter ports only
module ctf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              s_valid,
	input logic              s_ready,
	input logic              r_valid,
	input logic              r_ready,
	input logic signed [23:0] r_angle,
	input logic              r_upd
);

	logic               s_acc, r_acc;
	logic [1:0]         pend_q;
	logic signed [23:0] last_angle_q;
	logic               have_last_q;

	assign s_acc = s_valid && s_ready;
	assign r_acc = r_valid && r_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			have_last_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {1'b0, s_acc} - {1'b0, r_acc};
			if (r_acc) have_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (r_acc) last_angle_q <= r_angle;
	end

	// every result beat belongs to an accepted sample
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> pend_q != 2'd0)
		else $error("result without a pending sample");

	// one sample at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_ready)
		else $error("sample taken in consecutive cycles");

	// a rejected sample leaves the angle as it was
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		r_acc && !r_upd && have_last_q |-> r_angle == last_angle_q)
		else $error("rejected sample changed the angle");

	// stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_angle) && $stable(r_upd))
		else $error("stalled result changed");

endmodule

bind complementary_tilt_filter ctf_checker u_ctf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_angle (result.tilt_angle),
	.r_upd   (result.updated)
);
